### hdl/phvrr_pkg.sv
// Package: shared widths, codes and payload types of the per-host vCPU ring scheduler.
`timescale 1ns / 1ps
package phvrr_pkg;

	// Sizes of the scheduler state.
	localparam int MAX_HOSTS   = 8;
	localparam int NUM_SLOTS   = 32;
	localparam int NUM_GUESTS  = 16;
	localparam int QUEUE_DEPTH = 2;

	// Field widths.
	localparam int FUNC_W   = 3;
	localparam int HOST_W   = $clog2(MAX_HOSTS);
	localparam int SLOT_W   = $clog2(NUM_SLOTS);
	localparam int GUEST_W  = $clog2(NUM_GUESTS);
	localparam int STATUS_W = 2;
	localparam int OP_W     = 3;

	// Function codes on the request channel.
	localparam logic [FUNC_W-1:0] FUNC_REGISTER    = 3'd0;
	localparam logic [FUNC_W-1:0] FUNC_GET_CURRENT = 3'd1;
	localparam logic [FUNC_W-1:0] FUNC_SET_INITIAL = 3'd2;
	localparam logic [FUNC_W-1:0] FUNC_SCHED_INIT  = 3'd3;
	localparam logic [FUNC_W-1:0] FUNC_SCHED_NEXT  = 3'd4;
	localparam logic [FUNC_W-1:0] FUNC_SCHED_GUEST = 3'd5;

	// Status codes on the response channel.
	localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_EMPTY     = 2'd2;

	// Decoded operations passed from the front end to the back end.
	localparam logic [OP_W-1:0] OP_NOP         = 3'd0;
	localparam logic [OP_W-1:0] OP_BAD_HOST    = 3'd1;
	localparam logic [OP_W-1:0] OP_REGISTER    = 3'd2;
	localparam logic [OP_W-1:0] OP_GET_CURRENT = 3'd3;
	localparam logic [OP_W-1:0] OP_SET_INITIAL = 3'd4;
	localparam logic [OP_W-1:0] OP_SCHED_INIT  = 3'd5;
	localparam logic [OP_W-1:0] OP_SCHED_NEXT  = 3'd6;
	localparam logic [OP_W-1:0] OP_SCHED_GUEST = 3'd7;

	typedef logic [HOST_W-1:0]  host_t;
	typedef logic [SLOT_W-1:0]  slot_t;
	typedef logic [GUEST_W-1:0] guest_t;

	typedef struct packed {
		logic [OP_W-1:0] op;
		host_t           host;
		slot_t           slot;
		guest_t          guest_id;
	} cmd_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		slot_t               result_slot;
		logic                swap_out_valid;
		slot_t               swap_out_slot;
		logic                swap_in_valid;
		slot_t               swap_in_slot;
		logic                clear_nmi;
	} rsp_t;

endpackage

### hdl/phvrr_if.sv
// Interfaces: request and response channels of the ring scheduler.
`timescale 1ns / 1ps
interface phvrr_req_if;
	logic                          valid;
	logic                          ready;
	logic [phvrr_pkg::FUNC_W-1:0]  func;
	logic [phvrr_pkg::HOST_W-1:0]  host;
	logic [phvrr_pkg::SLOT_W-1:0]  slot;
	logic [phvrr_pkg::GUEST_W-1:0] guest_id;

	modport source (output valid, func, host, slot, guest_id, input ready);
	modport sink (input valid, func, host, slot, guest_id, output ready);
endinterface

interface phvrr_rsp_if;
	logic                           valid;
	logic                           ready;
	logic [phvrr_pkg::STATUS_W-1:0] status;
	logic [phvrr_pkg::SLOT_W-1:0]   result_slot;
	logic                           swap_out_valid;
	logic [phvrr_pkg::SLOT_W-1:0]   swap_out_slot;
	logic                           swap_in_valid;
	logic [phvrr_pkg::SLOT_W-1:0]   swap_in_slot;
	logic                           clear_nmi;

	modport source (output valid, status, result_slot, swap_out_valid, swap_out_slot,
		swap_in_valid, swap_in_slot, clear_nmi, input ready);
	modport sink (input valid, status, result_slot, swap_out_valid, swap_out_slot,
		swap_in_valid, swap_in_slot, clear_nmi, output ready);
endinterface

### hdl/phvrr_front.sv
// Front end: accepts request items and decodes them into ring operations.
`timescale 1ns / 1ps
module phvrr_front (
	phvrr_req_if.sink         req,
	input  logic              q_full,
	output logic              q_push,
	output phvrr_pkg::cmd_t   q_cmd
);
	import phvrr_pkg::*;

	logic [OP_W-1:0] op;

	always_comb begin
		case (req.func)
			FUNC_REGISTER:    op = OP_REGISTER;
			FUNC_GET_CURRENT: op = OP_GET_CURRENT;
			FUNC_SET_INITIAL: op = OP_SET_INITIAL;
			FUNC_SCHED_INIT:  op = OP_SCHED_INIT;
			FUNC_SCHED_NEXT:  op = OP_SCHED_NEXT;
			FUNC_SCHED_GUEST: op = OP_SCHED_GUEST;
			default:          op = OP_NOP;
		endcase
		// A host beyond the table is refused, but unused codes stay silent.
		if (op != OP_NOP && int'(req.host) >= MAX_HOSTS) begin
			op = OP_BAD_HOST;
		end
	end

	assign req.ready       = !q_full;
	assign q_push          = req.valid && !q_full;
	assign q_cmd.op        = op;
	assign q_cmd.host      = req.host;
	assign q_cmd.slot      = req.slot;
	assign q_cmd.guest_id  = req.guest_id;

endmodule

### hdl/phvrr_queue.sv
// Command queue: a short FIFO between the decoding front end and the ring back end.
`timescale 1ns / 1ps
module phvrr_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  phvrr_pkg::cmd_t push_cmd,
	input  logic            pop,
	output logic            full,
	output logic            not_empty,
	output phvrr_pkg::cmd_t head
);
	import phvrr_pkg::*;

	// The depth is a power of two so that the pointers wrap by themselves.
	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	cmd_t               mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;

	assign full      = (count_q == CNT_W'(QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign head      = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

### hdl/phvrr_back.sv
// Back end: ring memories, per-host tables, operation sequencer and response register.
`timescale 1ns / 1ps
module phvrr_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cmd_valid,
	input  phvrr_pkg::cmd_t cmd,
	output logic            cmd_pop,
	phvrr_rsp_if.source     rsp
);
	import phvrr_pkg::*;

	localparam logic [2:0] S_IDLE     = 3'd0;
	localparam logic [2:0] S_REG_RD   = 3'd1;
	localparam logic [2:0] S_REG_LINK = 3'd2;
	localparam logic [2:0] S_NEXT_RD  = 3'd3;
	localparam logic [2:0] S_SEARCH   = 3'd4;

	logic [2:0] state_q, state_d;
	cmd_t       cmd_q;
	slot_t      cur_q;
	slot_t      start_q;
	slot_t      srch_p_q, srch_p_d;
	slot_t      srch_cnt_q, srch_cnt_d;

	slot_t      host_cur_q [MAX_HOSTS];
	logic       host_occ_q [MAX_HOSTS];

	// Ring links and guest tags, read one slot per cycle.
	slot_t      next_mem [NUM_SLOTS];
	guest_t     guest_mem [NUM_SLOTS];
	slot_t      rd_next_q;
	guest_t     rd_guest_q;

	logic       out_valid_q;
	rsp_t       out_res_q;

	logic       go;
	slot_t      cur_i;
	logic       occ_i;
	host_t      hsel;
	logic       nx_we;
	slot_t      nx_waddr;
	slot_t      nx_wdata;
	logic       gs_we;
	slot_t      rd_addr;
	logic       cur_we;
	slot_t      cur_wdata;
	logic       occ_set;
	logic       res_load;
	rsp_t       res_d;
	slot_t      target;

	assign cur_i = host_cur_q[cmd.host];
	assign occ_i = host_occ_q[cmd.host];
	assign go    = (state_q == S_IDLE) && cmd_valid && (!out_valid_q || rsp.ready);
	assign cmd_pop = go;
	assign hsel  = (state_q == S_IDLE) ? cmd.host : cmd_q.host;

	always_comb begin
		state_d    = state_q;
		srch_p_d   = srch_p_q;
		srch_cnt_d = srch_cnt_q;
		nx_we      = 1'b0;
		nx_waddr   = cmd_q.slot;
		nx_wdata   = rd_next_q;
		gs_we      = 1'b0;
		rd_addr    = cur_i;
		cur_we     = 1'b0;
		cur_wdata  = cmd_q.slot;
		occ_set    = 1'b0;
		res_load   = 1'b0;
		res_d      = '0;
		target     = rd_next_q;

		case (state_q)
			S_IDLE: begin
				if (go) begin
					srch_p_d   = cur_i;
					srch_cnt_d = '0;
					res_load   = 1'b1;
					if (cmd.op == OP_NOP) begin
						res_d = '0;
					end else if (cmd.op == OP_BAD_HOST
							|| (cmd.op != OP_REGISTER && !occ_i)) begin
						res_d.status = STATUS_EMPTY;
					end else begin
						case (cmd.op)
							OP_REGISTER: begin
								if (!occ_i) begin
									// First slot on this host links to itself.
									nx_we    = 1'b1;
									nx_waddr = cmd.slot;
									nx_wdata = cmd.slot;
									gs_we    = 1'b1;
									cur_we   = 1'b1;
									cur_wdata = cmd.slot;
									occ_set  = 1'b1;
									res_d.result_slot = cmd.slot;
								end else begin
									res_load = 1'b0;
									state_d  = S_REG_RD;
								end
							end
							OP_GET_CURRENT: begin
								res_d.result_slot = cur_i;
							end
							OP_SCHED_INIT: begin
								res_d.result_slot   = cur_i;
								res_d.swap_in_valid = 1'b1;
								res_d.swap_in_slot  = cur_i;
							end
							OP_SCHED_NEXT: begin
								res_load = 1'b0;
								state_d  = S_NEXT_RD;
							end
							default: begin
								// Set initial and schedule to guest both search.
								res_load = 1'b0;
								state_d  = S_SEARCH;
							end
						endcase
					end
				end
			end
			S_REG_RD: begin
				// New slot takes over the successor of the current one.
				nx_we    = 1'b1;
				nx_waddr = cmd_q.slot;
				nx_wdata = rd_next_q;
				state_d  = S_REG_LINK;
			end
			S_REG_LINK: begin
				nx_we     = 1'b1;
				nx_waddr  = cur_q;
				nx_wdata  = cmd_q.slot;
				gs_we     = 1'b1;
				cur_we    = 1'b1;
				cur_wdata = cmd_q.slot;
				res_load  = 1'b1;
				res_d.result_slot = cmd_q.slot;
				state_d   = S_IDLE;
			end
			S_NEXT_RD: begin
				target   = rd_next_q;
				res_load = 1'b1;
				state_d  = S_IDLE;
				res_d.result_slot = target;
				if (target != cur_q) begin
					res_d.clear_nmi      = 1'b1;
					res_d.swap_out_valid = 1'b1;
					res_d.swap_out_slot  = cur_q;
					res_d.swap_in_valid  = 1'b1;
					res_d.swap_in_slot   = target;
					cur_we    = 1'b1;
					cur_wdata = target;
				end
			end
			S_SEARCH: begin
				target = srch_p_q;
				if (rd_guest_q == cmd_q.guest_id) begin
					res_load = 1'b1;
					state_d  = S_IDLE;
					res_d.result_slot = target;
					if (cmd_q.op == OP_SET_INITIAL) begin
						cur_we    = 1'b1;
						cur_wdata = target;
					end else if (target != cur_q) begin
						res_d.clear_nmi      = 1'b1;
						res_d.swap_out_valid = 1'b1;
						res_d.swap_out_slot  = cur_q;
						res_d.swap_in_valid  = 1'b1;
						res_d.swap_in_slot   = target;
						cur_we    = 1'b1;
						cur_wdata = target;
					end
				end else if (srch_cnt_q == SLOT_W'(NUM_SLOTS - 1) || rd_next_q == start_q) begin
					res_load = 1'b1;
					state_d  = S_IDLE;
					res_d.status      = STATUS_NOT_FOUND;
					res_d.result_slot = cur_q;
				end else begin
					rd_addr    = rd_next_q;
					srch_p_d   = rd_next_q;
					srch_cnt_d = srch_cnt_q + 1'b1;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (nx_we) begin
			next_mem[nx_waddr] <= nx_wdata;
		end
		if (gs_we) begin
			guest_mem[(state_q == S_IDLE) ? cmd.slot : cmd_q.slot] <=
				(state_q == S_IDLE) ? cmd.guest_id : cmd_q.guest_id;
		end
		rd_next_q  <= next_mem[rd_addr];
		rd_guest_q <= guest_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (go) begin
			cmd_q   <= cmd;
			cur_q   <= cur_i;
			start_q <= cur_i;
		end
		srch_p_q   <= srch_p_d;
		srch_cnt_q <= srch_cnt_d;
		if (res_load) begin
			out_res_q <= res_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			for (int i = 0; i < MAX_HOSTS; i++) begin
				host_cur_q[i] <= '0;
				host_occ_q[i] <= 1'b0;
			end
		end else begin
			state_q <= state_d;
			if (res_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			if (cur_we) begin
				host_cur_q[hsel] <= cur_wdata;
			end
			if (occ_set) begin
				host_occ_q[hsel] <= 1'b1;
			end
		end
	end

	assign rsp.valid          = out_valid_q;
	assign rsp.status         = out_res_q.status;
	assign rsp.result_slot    = out_res_q.result_slot;
	assign rsp.swap_out_valid = out_res_q.swap_out_valid;
	assign rsp.swap_out_slot  = out_res_q.swap_out_slot;
	assign rsp.swap_in_valid  = out_res_q.swap_in_valid;
	assign rsp.swap_in_slot   = out_res_q.swap_in_slot;
	assign rsp.clear_nmi      = out_res_q.clear_nmi;

endmodule

### hdl/per_host_vcpu_round_robin_ring.sv
// Top level of the per-host virtual-CPU round-robin ring scheduler.
`timescale 1ns / 1ps
// The block keeps, for each host CPU, a circular ring of virtual-CPU slots
// tagged with guest ids, and a current pointer per host. Each item on the
// req channel (func, host, slot, guest_id) performs one ring operation and
// gives exactly one item on the rsp channel, in order.
// A front end decodes accepted items into a two-entry command queue; the
// back end runs one command at a time against the link and guest memories.
// Responses are registered. Register on an empty ring, get current,
// schedule initial and error cases answer from the idle state; schedule
// next first reads the link memory; register on an occupied ring reads
// the successor and then links the new slot in; a guest search visits at
// most 32 slots, walking one ring link per cycle through the link memory.
// The back end can start a new command every cycle for operations that
// finish in the idle state while responses are taken; the other operations
// keep it busy until their last state is done.
// The front end keeps accepting while the queue has room, so up to two
// items can wait while a search runs or a result is held.
// At reset every host ring is empty and every current pointer is zero; the
// link and guest memories are not cleared, as only slots on a ring are read.
// A stalled receiver holds the response register, and the back end waits
// with the next command until the held item has been taken.
module per_host_vcpu_round_robin_ring (
	input  logic        clk,
	input  logic        arst_n,
	phvrr_req_if.sink   req,
	phvrr_rsp_if.source rsp
);
	import phvrr_pkg::*;

	logic q_full;
	logic q_push;
	logic q_pop;
	logic q_not_empty;
	cmd_t q_in;
	cmd_t q_head;

	phvrr_front u_front (
		.req    (req),
		.q_full (q_full),
		.q_push (q_push),
		.q_cmd  (q_in)
	);

	phvrr_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_cmd  (q_in),
		.pop       (q_pop),
		.full      (q_full),
		.not_empty (q_not_empty),
		.head      (q_head)
	);

	phvrr_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (q_not_empty),
		.cmd       (q_head),
		.cmd_pop   (q_pop),
		.rsp       (rsp)
	);

endmodule

### dv/phvrr_ring_checker.sv
// Checker: predicts every response of the ring scheduler and compares it with what the block returns.
`timescale 1ns / 1ps
module phvrr_ring_checker (
	input  logic        clk,
	input  logic        arst_n,
	phvrr_req_if        req,
	phvrr_rsp_if        rsp,
	output int unsigned fail_count,
	output int unsigned awaited_count,
	output int unsigned checked_count,
	output int unsigned switch_count,
	output int unsigned miss_count,
	output int unsigned empty_count
);
	import phvrr_pkg::*;

	typedef logic [FUNC_W-1:0] func_code_t;

	// Shadow copy of the scheduler state.
	slot_t  link_of  [NUM_SLOTS];
	guest_t guest_of [NUM_SLOTS];
	slot_t  cur_slot [MAX_HOSTS];
	logic   ring_live[MAX_HOSTS];

	// Responses still owed by the block, oldest first.
	rsp_t awaited_results[$];

	// Walks the ring from the current slot, visiting at most NUM_SLOTS links.
	function automatic logic seek_guest(input host_t h, input guest_t g, output slot_t hit);
		slot_t start;
		slot_t p;
		start = cur_slot[h];
		p = start;
		hit = '0;
		for (int n = 0; n < NUM_SLOTS; n++) begin
			if (guest_of[p] == g) begin
				hit = p;
				return 1'b1;
			end
			p = link_of[p];
			if (p == start)
				break;
		end
		return 1'b0;
	endfunction

	// Applies one request to the shadow state and returns the response it must give.
	function automatic rsp_t apply_ring_op(input func_code_t f, input host_t h, input slot_t s,
		input guest_t g);
		rsp_t  r;
		slot_t cur;
		slot_t target;
		logic  found;
		r = '0;
		if (f > FUNC_SCHED_GUEST)
			return r;
		if (f != FUNC_REGISTER && !ring_live[h]) begin
			r.status = STATUS_EMPTY;
			return r;
		end
		cur = cur_slot[h];
		case (f)
			FUNC_REGISTER: begin
				if (!ring_live[h]) begin
					ring_live[h] = 1'b1;
					cur = s;
					link_of[s] = s;
				end
				link_of[s] = link_of[cur];
				link_of[cur] = s;
				cur_slot[h] = s;
				guest_of[s] = g;
				r.result_slot = s;
			end
			FUNC_GET_CURRENT: r.result_slot = cur;
			FUNC_SET_INITIAL: begin
				if (seek_guest(h, g, target)) begin
					cur_slot[h] = target;
					r.result_slot = target;
				end else begin
					r.status = STATUS_NOT_FOUND;
					r.result_slot = cur;
				end
			end
			FUNC_SCHED_INIT: begin
				r.result_slot = cur;
				r.swap_in_valid = 1'b1;
				r.swap_in_slot = cur;
			end
			default: begin
				found = 1'b1;
				if (f == FUNC_SCHED_NEXT)
					target = link_of[cur];
				else
					found = seek_guest(h, g, target);
				if (!found) begin
					r.status = STATUS_NOT_FOUND;
					r.result_slot = cur;
				end else begin
					r.result_slot = target;
					if (target != cur) begin
						r.clear_nmi = 1'b1;
						r.swap_out_valid = 1'b1;
						r.swap_out_slot = cur;
						r.swap_in_valid = 1'b1;
						r.swap_in_slot = target;
						cur_slot[h] = target;
					end
				end
			end
		endcase
		return r;
	endfunction

	function automatic int field_diff(input string name, input logic [7:0] want,
		input logic [7:0] got);
		if (want === got)
			return 0;
		$display("%0t: %s expected %0d, got %0d", $time, name, want, got);
		return 1;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		rsp_t want;
		rsp_t got;
		int   bad;
		if (!arst_n) begin
			for (int i = 0; i < NUM_SLOTS; i++) begin
				link_of[i] = '0;
				guest_of[i] = '0;
			end
			for (int i = 0; i < MAX_HOSTS; i++) begin
				cur_slot[i] = '0;
				ring_live[i] = 1'b0;
			end
			awaited_results.delete();
			fail_count <= 0;
			awaited_count <= 0;
			checked_count <= 0;
			switch_count <= 0;
			miss_count <= 0;
			empty_count <= 0;
		end else begin
			if (req.valid && req.ready) begin
				want = apply_ring_op(req.func, req.host, req.slot, req.guest_id);
				awaited_results.push_back(want);
				if (want.clear_nmi)
					switch_count <= switch_count + 1;
				if (want.status == STATUS_NOT_FOUND)
					miss_count <= miss_count + 1;
				if (want.status == STATUS_EMPTY)
					empty_count <= empty_count + 1;
			end
			if (rsp.valid && rsp.ready) begin
				got = {rsp.status, rsp.result_slot, rsp.swap_out_valid, rsp.swap_out_slot,
					rsp.swap_in_valid, rsp.swap_in_slot, rsp.clear_nmi};
				if (awaited_results.size() == 0) begin
					$display("%0t: response with none awaited: expected nothing, got %h",
						$time, got);
					fail_count <= fail_count + 1;
				end else begin
					want = awaited_results.pop_front();
					bad = field_diff("status", 8'(want.status), 8'(got.status))
						+ field_diff("result_slot", 8'(want.result_slot), 8'(got.result_slot))
						+ field_diff("swap_out_valid", 8'(want.swap_out_valid),
							8'(got.swap_out_valid))
						+ field_diff("swap_out_slot", 8'(want.swap_out_slot),
							8'(got.swap_out_slot))
						+ field_diff("swap_in_valid", 8'(want.swap_in_valid),
							8'(got.swap_in_valid))
						+ field_diff("swap_in_slot", 8'(want.swap_in_slot), 8'(got.swap_in_slot))
						+ field_diff("clear_nmi", 8'(want.clear_nmi), 8'(got.clear_nmi));
					if (bad != 0)
						fail_count <= fail_count + 1;
					checked_count <= checked_count + 1;
				end
			end
			awaited_count <= awaited_results.size();
		end
	end

endmodule

### dv/per_host_vcpu_round_robin_ring_test.sv
// Testbench top: drives requests into the ring scheduler, paces the response side and reports the verdict.
`timescale 1ns / 1ps
module per_host_vcpu_round_robin_ring_test;
	import phvrr_pkg::*;

	typedef logic [FUNC_W-1:0] func_code_t;

	// The two function codes that the block must treat as no operation.
	localparam func_code_t FUNC_UNUSED_LO = 3'd6;
	localparam func_code_t FUNC_UNUSED_HI = 3'd7;

	// Shape of the run: a directed opening, a long stretch of well-formed
	// traffic, then random noise. The last QUIET_ITEMS items run without idling.
	localparam int WELL_FORMED_ITEMS = 330;
	localparam int NOISE_ITEMS       = 100;
	localparam int QUIET_ITEMS       = 80;
	localparam int QUIET_FROM        = 25 + WELL_FORMED_ITEMS + NOISE_ITEMS - QUIET_ITEMS;
	localparam int PRESSURE_AFTER    = 60;
	localparam int PRESSURE_CYCLES   = 120;
	localparam int DRAIN_CYCLES      = 40;

	logic clk;
	logic arst_n;

	phvrr_req_if req();
	phvrr_rsp_if rsp();

	int unsigned fail_count;
	int unsigned awaited_count;
	int unsigned checked_count;
	int unsigned switch_count;
	int unsigned miss_count;
	int unsigned empty_count;

	// Idling is allowed on both sides while this is set.
	bit idle_on;
	int sent_total;

	// What the stimulus knows about the rings: which slots have been handed
	// out, to which host and with which guest. Used only to aim searches at
	// guests that are likely to be present.
	bit     slot_taken[NUM_SLOTS];
	host_t  slot_owner[NUM_SLOTS];
	guest_t slot_guest_id[NUM_SLOTS];

	per_host_vcpu_round_robin_ring uut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req),
		.rsp   (rsp)
	);

	phvrr_ring_checker watch (
		.clk          (clk),
		.arst_n       (arst_n),
		.req          (req),
		.rsp          (rsp),
		.fail_count   (fail_count),
		.awaited_count(awaited_count),
		.checked_count(checked_count),
		.switch_count (switch_count),
		.miss_count   (miss_count),
		.empty_count  (empty_count)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard stop in case the block hangs or loses an item.
	initial begin
		#2_000_000;
		$display("tb: failure");
		$finish;
	end

	// Offers one item and returns once the block has taken it. With idling on,
	// a random gap with valid low may come first. Valid is
	// never lowered and raised within one time step.
	task automatic offer_request(input func_code_t f, input host_t h, input slot_t s,
		input guest_t g);
		int gap;
		if (idle_on && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 6);
			req.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req.valid <= 1'b1;
		req.func <= f;
		req.host <= h;
		req.slot <= s;
		req.guest_id <= g;
		if (f == FUNC_REGISTER) begin
			slot_taken[s] = 1'b1;
			slot_owner[s] = h;
			slot_guest_id[s] = g;
		end
		@(posedge clk);
		while (!req.ready) @(posedge clk);
		sent_total++;
	endtask

	// Response side. It stalls in random bursts while idling is allowed, and
	// once, after the first few dozen responses, it holds ready low for a long
	// stretch so that the command queue fills and the block stops taking items.
	initial begin
		int  stall_left;
		bit  pressed;
		stall_left = 0;
		pressed = 1'b0;
		rsp.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (!pressed && checked_count >= PRESSURE_AFTER) begin
				pressed = 1'b1;
				rsp.ready <= 1'b0;
				repeat (PRESSURE_CYCLES) @(posedge clk);
			end else if (stall_left > 0) begin
				stall_left--;
				rsp.ready <= 1'b0;
			end else if (idle_on && $urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(1, 6) - 1;
				rsp.ready <= 1'b0;
			end else begin
				rsp.ready <= 1'b1;
			end
		end
	end

	initial begin
		host_t      h;
		slot_t      s;
		guest_t     g;
		func_code_t f;
		int         free;
		guest_t     known[$];

		arst_n <= 1'b0;
		req.valid <= 1'b0;
		req.func <= FUNC_REGISTER;
		req.host <= '0;
		req.slot <= '0;
		req.guest_id <= '0;
		idle_on <= 1'b1;
		sent_total = 0;
		for (int i = 0; i < NUM_SLOTS; i++) begin
			slot_taken[i] = 1'b0;
			slot_owner[i] = '0;
			slot_guest_id[i] = '0;
		end

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed opening. Every operation first meets an empty ring, then
		// the unused function codes are tried, and a two-slot ring on host 7
		// is built at the extremes of slot and guest values and driven through
		// switches, searches that hit the current slot, misses and a repeated
		// registration that cuts a slot off the ring.
		offer_request(FUNC_GET_CURRENT, 3'd0, 5'd0, 4'd0);
		offer_request(FUNC_SET_INITIAL, 3'd0, 5'd0, 4'd15);
		offer_request(FUNC_SCHED_INIT, 3'd0, 5'd0, 4'd0);
		offer_request(FUNC_SCHED_NEXT, 3'd0, 5'd0, 4'd0);
		offer_request(FUNC_SCHED_GUEST, 3'd0, 5'd0, 4'd0);
		offer_request(FUNC_UNUSED_LO, 3'd3, 5'd31, 4'd15);
		offer_request(FUNC_UNUSED_HI, 3'd7, 5'd31, 4'd15);
		offer_request(FUNC_REGISTER, 3'd7, 5'd31, 4'd15);
		// A ring of one slot: scheduling next or to its own guest does not switch.
		offer_request(FUNC_SCHED_NEXT, 3'd7, 5'd0, 4'd0);
		offer_request(FUNC_SCHED_GUEST, 3'd7, 5'd0, 4'd15);
		offer_request(FUNC_REGISTER, 3'd7, 5'd7, 4'd0);
		offer_request(FUNC_GET_CURRENT, 3'd7, 5'd0, 4'd0);
		offer_request(FUNC_SCHED_INIT, 3'd7, 5'd0, 4'd0);
		offer_request(FUNC_SET_INITIAL, 3'd7, 5'd0, 4'd15);
		offer_request(FUNC_SET_INITIAL, 3'd7, 5'd0, 4'd9);
		offer_request(FUNC_SCHED_NEXT, 3'd7, 5'd0, 4'd0);
		offer_request(FUNC_SCHED_GUEST, 3'd7, 5'd0, 4'd15);
		offer_request(FUNC_SCHED_GUEST, 3'd7, 5'd0, 4'd4);
		offer_request(FUNC_REGISTER, 3'd0, 5'd0, 4'd0);
		offer_request(FUNC_REGISTER, 3'd0, 5'd16, 4'd8);
		offer_request(FUNC_SCHED_NEXT, 3'd0, 5'd0, 4'd0);
		offer_request(FUNC_GET_CURRENT, 3'd7, 5'd0, 4'd0);
		// Registering the current slot again leaves it linked to itself, so
		// slot 7 drops off the ring and can no longer be found.
		offer_request(FUNC_REGISTER, 3'd7, 5'd31, 4'd15);
		offer_request(FUNC_SCHED_NEXT, 3'd7, 5'd0, 4'd0);
		offer_request(FUNC_SET_INITIAL, 3'd7, 5'd0, 4'd0);

		// Well-formed traffic: each free slot is registered once, mostly on the
		// low hosts so that their rings grow long, and the other operations
		// search mostly for guests known to sit on the chosen host's ring.
		for (int n = 0; n < WELL_FORMED_ITEMS; n++) begin
			idle_on <= !(sent_total >= 150 && sent_total < 190) && sent_total < QUIET_FROM;
			if ($urandom_range(0, 1) != 0)
				h = host_t'($urandom_range(0, 2));
			else
				h = host_t'($urandom_range(0, MAX_HOSTS - 1));
			free = 0;
			known.delete();
			for (int i = 0; i < NUM_SLOTS; i++) begin
				if (!slot_taken[i])
					free++;
				else if (slot_owner[i] == h)
					known.push_back(slot_guest_id[i]);
			end
			if (free != 0 && $urandom_range(0, 9) < 3) begin
				do s = slot_t'($urandom_range(0, NUM_SLOTS - 1)); while (slot_taken[s]);
				offer_request(FUNC_REGISTER, h, s, guest_t'($urandom_range(0, NUM_GUESTS - 1)));
			end else begin
				f = func_code_t'($urandom_range(FUNC_GET_CURRENT, FUNC_SCHED_GUEST));
				if (known.size() != 0 && $urandom_range(0, 3) != 0)
					g = known[$urandom_range(0, known.size() - 1)];
				else
					g = guest_t'($urandom_range(0, NUM_GUESTS - 1));
				offer_request(f, h, slot_t'($urandom_range(0, NUM_SLOTS - 1)), g);
			end
		end

		// Noise: any code, any host, any slot. Registrations here land on
		// slots already in use, possibly on another host's ring, and so break
		// rings apart; searches must still end after one lap at most.
		for (int n = 0; n < NOISE_ITEMS; n++) begin
			idle_on <= sent_total < QUIET_FROM;
			offer_request(func_code_t'($urandom_range(FUNC_REGISTER, FUNC_UNUSED_HI)),
				host_t'($urandom_range(0, MAX_HOSTS - 1)),
				slot_t'($urandom_range(0, NUM_SLOTS - 1)),
				guest_t'($urandom_range(0, NUM_GUESTS - 1)));
		end

		req.valid <= 1'b0;
		@(posedge clk);
		while (awaited_count != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("tb: %0d requests issued, %0d responses compared field by field",
			sent_total, checked_count);
		$display("tb: %0d slot switches, %0d guest misses, %0d empty-ring replies",
			switch_count, miss_count, empty_count);
		if (fail_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
